FILE: sv/sra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sra_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int MEM_AW       = SEG_AW + 1;
  localparam int MEM_DEPTH    = 2 * MAX_SEGMENTS;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 2);

  localparam int CRD_W  = 13;
  localparam int REQ_W  = 12;
  localparam int AREA_W = 25;
  localparam int PROD_W = 2 * REQ_W;

  localparam logic [CRD_W-1:0]  ATLAS_RST = CRD_W'(512);
  localparam logic [AREA_W-1:0] AREA_MAX  = {AREA_W{1'b1}};

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_H = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] w;
  } seg_t;

  typedef struct packed {
    logic             mode;
    logic [REQ_W-1:0] req_width;
    logic [REQ_W-1:0] req_height;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [REQ_W-1:0]  region_x;
    logic [REQ_W-1:0]  region_y;
    logic [AREA_W-1:0] used_area;
  } out_res_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    seg_t              wdata;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_FS_RD, S_FS_CHK, S_WK_RD, S_WK_CHK, S_NEXT,
    S_BUILD, S_BL_SEL, S_BL_NEW, S_BL_OLD, S_BL_FLUSH, S_FIN, S_RESP
  } state_t;

endpackage
`default_nettype wire

FILE: sv/sra_seg_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module sra_seg_mem (
  input  wire logic            clk,
  input  wire sra_pkg::mem_req_t req,
  output sra_pkg::seg_t        rdata
);
  import sra_pkg::*;

  seg_t mem [MEM_DEPTH];
  seg_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: sv/sra_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sra_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire sra_pkg::in_req_t           in_req,
  input  wire logic [sra_pkg::CRD_W-1:0]  atlas_w,
  input  wire logic [sra_pkg::CRD_W-1:0]  atlas_h,
  input  wire sra_pkg::seg_t              rd_data,
  output sra_pkg::mem_req_t               mem_req,
  output logic                            busy,
  output logic                            out_valid,
  output sra_pkg::out_res_t               out_res
);
  import sra_pkg::*;

  state_t state_r, state_nxt;

  logic              bank_r, bank_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AREA_W-1:0] area_r, area_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_res_r, out_res_nxt;

  logic [REQ_W-1:0]  w_r, w_nxt, h_r, h_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [CNT_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, n_r, n_nxt;
  logic [CNT_W-1:0]  best_r, best_nxt;
  logic [CRD_W-1:0]  sx_r, sx_nxt, sw_r, sw_nxt, y_r, y_nxt;
  logic [CRD_W:0]    cov_r, cov_nxt, best_top_r, best_top_nxt;
  logic [CRD_W-1:0]  best_w_r, best_w_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic              found_r, found_nxt, trim_r, trim_nxt, new_done_r, new_done_nxt;
  seg_t              acc_r, acc_nxt;
  logic              acc_v_r, acc_v_nxt;
  logic [1:0]        stat_r, stat_nxt;

  // shared compare and add unit
  logic [CRD_W-1:0] y_max;
  logic [CRD_W:0]   top, cov_sum, new_end, old_end;
  logic             x_over, y_over, cover_ok, better;
  seg_t             elem;
  logic             drop;
  logic [AREA_W:0]  area_sum;

  always_comb begin
    y_max    = (rd_data.y > y_r) ? rd_data.y : y_r;
    x_over   = ({1'b0, rd_data.x} + {2'b0, w_r} + (CRD_W+1)'(1)) > {1'b0, atlas_w};
    y_over   = ({1'b0, y_max} + {2'b0, h_r} + (CRD_W+1)'(1)) > {1'b0, atlas_h};
    top      = {1'b0, y_max} + {2'b0, h_r};
    cov_sum  = cov_r + {1'b0, rd_data.w};
    cover_ok = cov_sum >= {2'b0, w_r};
    better   = !found_r || (top < best_top_r) ||
               ((top == best_top_r) && (sw_r < best_w_r));
    new_end  = {1'b0, bx_r} + {2'b0, w_r};
    old_end  = {1'b0, rd_data.x} + {1'b0, rd_data.w};
    area_sum = {1'b0, area_r} + {2'b0, prod_r};
  end

  always_comb begin
    drop = 1'b0;
    elem = rd_data;
    if (state_r == S_BL_NEW) begin
      elem.x = bx_r;
      elem.y = by_r + CRD_W'(h_r);
      elem.w = {1'b0, w_r};
    end else if (trim_r && ({1'b0, rd_data.x} < new_end)) begin
      if (old_end <= new_end) begin
        drop = 1'b1;
      end else begin
        elem.x = new_end[CRD_W-1:0];
        elem.w = CRD_W'(old_end - new_end);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (in_req.mode == MODE_CLEAR) begin
            state_nxt = S_CLR;
          end else if (in_req.req_width == '0 || in_req.req_height == '0) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_FS_RD;
          end
        end
      end
      S_CLR:    state_nxt = S_RESP;
      S_FS_RD:  state_nxt = S_FS_CHK;
      S_FS_CHK: state_nxt = x_over ? S_NEXT : S_WK_RD;
      S_WK_RD:  state_nxt = (j_r >= cnt_r) ? S_NEXT : S_WK_CHK;
      S_WK_CHK: begin
        if (y_over || cover_ok) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_WK_RD;
        end
      end
      S_NEXT: begin
        if (i_r + CNT_W'(1) < cnt_r) begin
          state_nxt = S_FS_RD;
        end else begin
          state_nxt = found_r ? S_BUILD : S_RESP;
        end
      end
      S_BUILD: state_nxt = S_BL_SEL;
      S_BL_SEL: begin
        if (!new_done_r && k_r == best_r) begin
          state_nxt = S_BL_NEW;
        end else if (k_r < cnt_r) begin
          state_nxt = S_BL_OLD;
        end else begin
          state_nxt = S_BL_FLUSH;
        end
      end
      S_BL_NEW:   state_nxt = S_BL_SEL;
      S_BL_OLD:   state_nxt = S_BL_SEL;
      S_BL_FLUSH: state_nxt = S_FIN;
      S_FIN:      state_nxt = S_RESP;
      S_RESP:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    bank_nxt      = bank_r;
    cnt_nxt       = cnt_r;
    area_nxt      = area_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    best_nxt      = best_r;
    sx_nxt        = sx_r;
    sw_nxt        = sw_r;
    y_nxt         = y_r;
    cov_nxt       = cov_r;
    best_top_nxt  = best_top_r;
    best_w_nxt    = best_w_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    found_nxt     = found_r;
    trim_nxt      = trim_r;
    new_done_nxt  = new_done_r;
    acc_nxt       = acc_r;
    acc_v_nxt     = acc_v_r;
    stat_nxt      = stat_r;
    mem_req       = '0;
    mem_req.raddr = {bank_r, i_r[SEG_AW-1:0]};

    unique case (state_r)
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = '0;
        mem_req.wdata = '{x: CRD_W'(1), y: CRD_W'(1), w: ATLAS_RST - CRD_W'(2)};
      end
      S_IDLE: begin
        if (start) begin
          w_nxt     = in_req.req_width;
          h_nxt     = in_req.req_height;
          i_nxt     = '0;
          found_nxt = 1'b0;
          stat_nxt  = ST_NOSPACE;
        end
      end
      S_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {bank_r, SEG_AW'(0)};
        mem_req.wdata = '{x: CRD_W'(1), y: CRD_W'(1),
                          w: (atlas_w > CRD_W'(2)) ? atlas_w - CRD_W'(2) : '0};
        cnt_nxt       = CNT_W'(1);
        area_nxt      = '0;
        stat_nxt      = ST_CLEARED;
      end
      S_FS_RD: ;
      S_FS_CHK: begin
        sx_nxt  = rd_data.x;
        sw_nxt  = rd_data.w;
        y_nxt   = rd_data.y;
        cov_nxt = '0;
        j_nxt   = i_r;
      end
      S_WK_RD: mem_req.raddr = {bank_r, j_r[SEG_AW-1:0]};
      S_WK_CHK: begin
        y_nxt   = y_max;
        cov_nxt = cov_sum;
        j_nxt   = j_r + CNT_W'(1);
        if (!y_over && cover_ok && better) begin
          found_nxt    = 1'b1;
          best_top_nxt = top;
          best_w_nxt   = sw_r;
          best_nxt     = i_r;
          bx_nxt       = sx_r;
          by_nxt       = y_max;
        end
      end
      S_NEXT: i_nxt = i_r + CNT_W'(1);
      S_BUILD: begin
        k_nxt        = '0;
        n_nxt        = '0;
        acc_v_nxt    = 1'b0;
        trim_nxt     = 1'b0;
        new_done_nxt = 1'b0;
      end
      S_BL_SEL: mem_req.raddr = {bank_r, k_r[SEG_AW-1:0]};
      S_BL_NEW, S_BL_OLD: begin
        if (state_r == S_BL_NEW) begin
          new_done_nxt = 1'b1;
          trim_nxt     = 1'b1;
        end else begin
          k_nxt    = k_r + CNT_W'(1);
          trim_nxt = trim_r && drop;
        end
        if (!drop) begin
          if (acc_v_r && acc_r.y == elem.y) begin
            acc_nxt.w = acc_r.w + elem.w;
          end else begin
            if (acc_v_r) begin
              mem_req.we    = (n_r < CNT_W'(MAX_SEGMENTS));
              mem_req.waddr = {~bank_r, n_r[SEG_AW-1:0]};
              mem_req.wdata = acc_r;
              n_nxt         = n_r + CNT_W'(1);
            end
            acc_nxt   = elem;
            acc_v_nxt = 1'b1;
          end
        end
      end
      S_BL_FLUSH: begin
        if (acc_v_r) begin
          mem_req.we    = (n_r < CNT_W'(MAX_SEGMENTS));
          mem_req.waddr = {~bank_r, n_r[SEG_AW-1:0]};
          mem_req.wdata = acc_r;
          n_nxt         = n_r + CNT_W'(1);
        end
      end
      S_FIN: begin
        if (n_r > CNT_W'(MAX_SEGMENTS)) begin
          stat_nxt = ST_FULL;
        end else begin
          stat_nxt = ST_PLACED;
          bank_nxt = ~bank_r;
          cnt_nxt  = n_r;
          area_nxt = (area_sum > {1'b0, AREA_MAX}) ? AREA_MAX : area_sum[AREA_W-1:0];
        end
      end
      S_RESP: begin
        out_valid_nxt       = 1'b1;
        out_res_nxt.status  = stat_r;
        out_res_nxt.region_x = (stat_r == ST_PLACED) ? bx_r[REQ_W-1:0] : '0;
        out_res_nxt.region_y = (stat_r == ST_PLACED) ? by_r[REQ_W-1:0] : '0;
        out_res_nxt.used_area = area_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      bank_r      <= 1'b0;
      cnt_r       <= CNT_W'(1);
      area_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      cnt_r       <= cnt_nxt;
      area_r      <= area_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    prod_r     <= w_r * h_r;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    best_r     <= best_nxt;
    sx_r       <= sx_nxt;
    sw_r       <= sw_nxt;
    y_r        <= y_nxt;
    cov_r      <= cov_nxt;
    best_top_r <= best_top_nxt;
    best_w_r   <= best_w_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    found_r    <= found_nxt;
    trim_r     <= trim_nxt;
    new_done_r <= new_done_nxt;
    acc_r      <= acc_nxt;
    acc_v_r    <= acc_v_nxt;
    stat_r     <= stat_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

FILE: sv/skyline_rect_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// a clear or a zero-sized request goes straight to the response; an allocation tries every
// segment as a start position, then rebuilds the skyline into the other bank
// a request with no fit gives its response without the rebuild
// throughput: one request at a time, set by the single read port segment memory walk
// result strobe lasts one cycle and the receiver cannot stall
// reset: synchronous active low; the default segment is loaded in S_INIT before start is taken
module skyline_rect_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire sra_pkg::in_req_t              in_req,
  output logic                               out_valid,
  output sra_pkg::out_res_t                  out_res,
  input  wire logic                          cfg_we,
  input  wire logic [sra_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [sra_pkg::CRD_W-1:0]     cfg_wdata
);
  import sra_pkg::*;

  logic [CRD_W-1:0] atlas_w_r, atlas_h_r;
  mem_req_t         mem_req;
  seg_t             rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= ATLAS_RST;
      atlas_h_r <= ATLAS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ATLAS_W: atlas_w_r <= cfg_wdata;
        REG_ATLAS_H: atlas_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sra_seg_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rd_data)
  );

  sra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .atlas_w   (atlas_w_r),
    .atlas_h   (atlas_h_r),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

FILE: sv/sra_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sra_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire sra_pkg::out_res_t out_res
);
  import sra_pkg::*;

  // a request in flight holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy low after request");

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_region_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != ST_PLACED |-> out_res.region_x == '0 &&
    out_res.region_y == '0) else $error("region set without placement");

  a_clear_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status == ST_CLEARED |-> out_res.used_area == '0)
    else $error("area not zero after clear");

endmodule

bind skyline_rect_allocator sra_checker u_sra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);
`default_nettype wire
